// ----- design/fixed_point_decimal_formatter_core_defines.svh -----
// Assertion macros shared by the checker.
// Both sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef FIXED_POINT_DECIMAL_FORMATTER_CORE_DEFINES_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fpdf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpdf_pkg;

	localparam int DIGIT_W = 4;
	localparam int BITS_PER_STEP = 4;
	localparam int NUM_W = 5;
	localparam int CHAR_W = 8;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [CFG_IDX_W-1:0] REG_INT_DIGITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRACT_DIGITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd2;

	localparam num_t INT_DIGITS_RST = 5'd8;
	localparam num_t FRACT_DIGITS_RST = 5'd2;
	localparam char_t SEPARATOR_RST = 8'h2E;

	localparam char_t CH_NUL = 8'h00;
	localparam char_t CH_ZERO = 8'h30;
	localparam char_t CH_NINE = 8'h39;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_MINUS = 8'h2D;

	typedef struct packed {
		logic clear;
		logic step;
	} cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic neg;
	} conv_status_t;

endpackage

`default_nettype wire

// ----- design/fpdf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpdf_cell (
	input  wire logic                                   clk,
	input  wire fpdf_pkg::cell_ctl_t                    ctl,
	input  wire logic [fpdf_pkg::BITS_PER_STEP-1:0]     in_bits,
	output logic      [fpdf_pkg::BITS_PER_STEP-1:0]     out_bits,
	output fpdf_pkg::digit_t                            digit
);

	fpdf_pkg::digit_t digit_q;
	fpdf_pkg::digit_t digit_d;

	// Shift-and-add-3 over several bits: the bit shifted in at each step comes from
	// the lower neighbor, the bit shifted out goes to the upper neighbor.
	always_comb begin
		fpdf_pkg::digit_t d;
		d = digit_q;
		for (int j = fpdf_pkg::BITS_PER_STEP - 1; j >= 0; j--) begin
			if (d >= 4'd5) begin
				d = d + 4'd3;
			end
			out_bits[j] = d[3];
			d = {d[2:0], in_bits[j]};
		end
		digit_d = d;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.step) begin
			digit_q <= digit_d;
		end
	end

	assign digit = digit_q;

endmodule

`default_nettype wire

// ----- design/fpdf_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpdf_conv #(
	parameter int VALUE_WIDTH = 32,
	parameter int DIGITS = 10
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0]               value,
	input  wire logic                                        in_valid,
	output logic                                             in_stall,
	input  wire logic                                        load,
	output fpdf_pkg::conv_status_t                           conv,
	output logic [DIGITS*fpdf_pkg::DIGIT_W-1:0]              digits
);

	localparam int K = fpdf_pkg::BITS_PER_STEP;
	localparam int STEPS = (VALUE_WIDTH + K - 1) / K;
	localparam int MAG_W = STEPS * K;
	localparam int STEP_CNT_W = $clog2(STEPS + 1);

	logic                    busy_q;
	logic                    hold_q;
	logic                    neg_q;
	logic [STEP_CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]        bits_q;

	logic [VALUE_WIDTH-1:0]  raw;
	logic [VALUE_WIDTH-1:0]  mag;
	logic                    accept;
	logic                    finish;
	fpdf_pkg::cell_ctl_t     cell_ctl;
	logic [K-1:0]            carry [DIGITS-1];

	assign raw = value;
	// The most negative value maps onto itself, which read unsigned is its magnitude.
	assign mag = raw[VALUE_WIDTH-1] ? ((~raw) + VALUE_WIDTH'(1)) : raw;

	assign in_stall = busy_q || (hold_q && !load);
	assign accept = in_valid && !in_stall;
	assign finish = busy_q && (cnt_q == STEP_CNT_W'(1));

	assign cell_ctl.clear = accept;
	assign cell_ctl.step = busy_q;

	assign conv.valid = hold_q;
	assign conv.neg = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hold_q <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_CNT_W'(STEPS);
				neg_q <= raw[VALUE_WIDTH-1];
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_CNT_W'(1);
				if (finish) begin
					busy_q <= 1'b0;
				end
			end
			if (finish) begin
				hold_q <= 1'b1;
			end else if (load) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_q <= MAG_W'(mag);
		end else if (busy_q) begin
			bits_q <= {bits_q[MAG_W-K-1:0], {K{1'b0}}};
		end
	end

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		logic [K-1:0] cin;
		if (i == 0) begin : g_first
			assign cin = bits_q[MAG_W-1 -: K];
		end else begin : g_rest
			assign cin = carry[i-1];
		end
		if (i < DIGITS - 1) begin : g_mid
			fpdf_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl),
				.in_bits  (cin),
				.out_bits (carry[i]),
				.digit    (digits[i*fpdf_pkg::DIGIT_W +: fpdf_pkg::DIGIT_W])
			);
		end else begin : g_top
			fpdf_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl),
				.in_bits  (cin),
				.out_bits (),
				.digit    (digits[i*fpdf_pkg::DIGIT_W +: fpdf_pkg::DIGIT_W])
			);
		end
	end

endmodule

`default_nettype wire

// ----- design/fpdf_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpdf_emit #(
	parameter int DIGITS = 10
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire fpdf_pkg::num_t                         int_digits,
	input  wire fpdf_pkg::num_t                         fract_digits,
	input  wire fpdf_pkg::char_t                        separator_char,
	input  wire logic [DIGITS*fpdf_pkg::DIGIT_W-1:0]    digits,
	input  wire fpdf_pkg::conv_status_t                 conv,
	output logic                                        load,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output fpdf_pkg::char_t                             text_char,
	output logic                                        last_char,
	output logic                                        empty_text
);

	localparam int DW = fpdf_pkg::DIGIT_W;
	localparam int EM_W = DIGITS * DW;
	localparam fpdf_pkg::cnt_t DIG_C = fpdf_pkg::cnt_t'(DIGITS);

	logic              busy_q;
	logic              lead_q;
	logic              neg_q;
	fpdf_pkg::cnt_t    k_q;
	fpdf_pkg::cnt_t    pad_q;
	logic [EM_W-1:0]   em_q;
	logic              out_valid_q;
	fpdf_pkg::char_t   char_q;
	logic              last_q;
	logic              empty_q;

	fpdf_pkg::cnt_t    ni_c;
	fpdf_pkg::cnt_t    num_total;
	fpdf_pkg::cnt_t    text_len;
	fpdf_pkg::cnt_t    sh;
	logic              adv;
	logic              is_empty;
	logic              is_last;
	logic              is_int;
	logic              is_sep;
	logic              is_units;
	logic              next_units;
	logic              take;
	fpdf_pkg::digit_t  hd;
	fpdf_pkg::digit_t  nd;
	fpdf_pkg::char_t   char_d;
	logic [EM_W-1:0]   em_load;

	assign ni_c = fpdf_pkg::cnt_t'(int_digits);
	assign num_total = ni_c + fpdf_pkg::cnt_t'(fract_digits);
	assign text_len = (fract_digits != '0) ? (num_total + fpdf_pkg::cnt_t'(1)) : ni_c;

	assign is_empty = (num_total == '0);
	assign is_last = is_empty || ((k_q + fpdf_pkg::cnt_t'(1)) == text_len);
	assign is_int = (k_q < ni_c);
	assign is_sep = !is_empty && (k_q == ni_c);
	assign is_units = ((k_q + fpdf_pkg::cnt_t'(1)) == ni_c);
	assign next_units = ((k_q + fpdf_pkg::cnt_t'(2)) == ni_c);

	assign adv = busy_q && (!out_valid_q || !out_stall);
	assign load = conv.valid && (!busy_q || (adv && is_last));
	assign take = adv && !is_empty && !is_sep;

	// Digits above the converted width are zeros still owed before the row.
	assign hd = (pad_q != '0) ? '0 : em_q[EM_W-1 -: DW];
	always_comb begin
		if (pad_q > fpdf_pkg::cnt_t'(1)) begin
			nd = '0;
		end else if (pad_q == fpdf_pkg::cnt_t'(1)) begin
			nd = em_q[EM_W-1 -: DW];
		end else begin
			nd = em_q[EM_W-DW-1 -: DW];
		end
	end

	// A short text drops the high digits: they are shifted out past the head.
	assign sh = (num_total < DIG_C) ? (DIG_C - num_total) : '0;
	assign em_load = digits << (sh * DW);

	always_comb begin
		char_d = fpdf_pkg::CH_ZERO + fpdf_pkg::char_t'(hd);
		if (is_empty) begin
			char_d = fpdf_pkg::CH_NUL;
		end else if (is_sep) begin
			char_d = separator_char;
		end else if (is_int && lead_q && !is_units && (hd == '0)) begin
			// The rightmost blank carries the sign.
			if (neg_q && ((nd != '0) || next_units)) begin
				char_d = fpdf_pkg::CH_MINUS;
			end else begin
				char_d = fpdf_pkg::CH_SPACE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lead_q <= 1'b0;
			neg_q <= 1'b0;
			k_q <= '0;
			pad_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q <= '0;
				lead_q <= 1'b1;
				neg_q <= conv.neg;
				pad_q <= (num_total > DIG_C) ? (num_total - DIG_C) : '0;
			end else begin
				if (adv) begin
					k_q <= k_q + fpdf_pkg::cnt_t'(1);
					if (is_last) begin
						busy_q <= 1'b0;
					end
				end
				if (take && is_int) begin
					lead_q <= lead_q && (hd == '0);
				end
				if (take && (pad_q != '0)) begin
					pad_q <= pad_q - fpdf_pkg::cnt_t'(1);
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_q <= em_load;
		end else if (take && (pad_q == '0)) begin
			em_q <= {em_q[EM_W-DW-1:0], {DW{1'b0}}};
		end
		if (adv) begin
			char_q <= char_d;
			last_q <= is_last;
			empty_q <= is_empty;
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;
	assign empty_text = empty_q;

endmodule

`default_nettype wire

// ----- design/fixed_point_decimal_formatter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Signed binary to fixed-width decimal text.
// Input channel (in_valid / in_stall, payload value): one signed number per item.
// Output channel (out_valid / out_stall): one character per item, left to right,
// with last_char on the final character; empty_text marks the single item sent
// when both digit counts are zero. Registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. A number is converted in a row of
// BCD digit cells, four bits per cycle. Characters then leave at one per cycle
// from a second digit row while the output does not stall. While one text
// drains, the next number is converted; the text length is int_digits +
// fract_digits + 1 with a separator, 11 with the reset settings. Reset clears
// the control state but not the rows, and restores 8 integer digits,
// 2 fraction digits and '.'. A stall on the output holds the character and
// stops the text row; in_stall rises once the converted number waits for the
// text row.

module fixed_point_decimal_formatter_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0]           value,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic [fpdf_pkg::CHAR_W-1:0]                  text_char,
	output logic                                         last_char,
	output logic                                         empty_text,
	input  wire logic                                    cfg_wr_en,
	input  wire logic [fpdf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [fpdf_pkg::CFG_DATA_W-1:0]         cfg_data
);

	// Decimal digits needed for any magnitude of VALUE_WIDTH bits.
	localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

	fpdf_pkg::num_t          int_digits_q;
	fpdf_pkg::num_t          fract_digits_q;
	fpdf_pkg::char_t         separator_q;

	fpdf_pkg::conv_status_t  conv;
	logic                    load;
	logic [DIGITS*fpdf_pkg::DIGIT_W-1:0] digits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_digits_q <= fpdf_pkg::INT_DIGITS_RST;
			fract_digits_q <= fpdf_pkg::FRACT_DIGITS_RST;
			separator_q <= fpdf_pkg::SEPARATOR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fpdf_pkg::REG_INT_DIGITS: begin
					int_digits_q <= cfg_data[fpdf_pkg::NUM_W-1:0];
				end
				fpdf_pkg::REG_FRACT_DIGITS: begin
					fract_digits_q <= cfg_data[fpdf_pkg::NUM_W-1:0];
				end
				fpdf_pkg::REG_SEPARATOR: begin
					separator_q <= cfg_data[fpdf_pkg::CHAR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fpdf_conv #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGITS      (DIGITS)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (value),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.load     (load),
		.conv     (conv),
		.digits   (digits)
	);

	fpdf_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.int_digits     (int_digits_q),
		.fract_digits   (fract_digits_q),
		.separator_char (separator_q),
		.digits         (digits),
		.conv           (conv),
		.load           (load),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.text_char      (text_char),
		.last_char      (last_char),
		.empty_text     (empty_text)
	);

endmodule

`default_nettype wire

// ----- design/fpdf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_point_decimal_formatter_core_defines.svh"

module fpdf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [fpdf_pkg::CHAR_W-1:0]   text_char,
	input wire logic                          last_char,
	input wire logic                          empty_text
);

	// The marker for a missing text is a single item holding a null character.
	`FPDF_ASSERT_NOW(a_empty_alone, out_valid && empty_text, last_char && (text_char == fpdf_pkg::CH_NUL), "empty marker is not a lone null item")

	// A text always ends on a digit: a fraction digit or the units digit.
	`FPDF_ASSERT_NOW(a_last_is_digit, out_valid && last_char && !empty_text, (text_char >= fpdf_pkg::CH_ZERO) && (text_char <= fpdf_pkg::CH_NINE), "text does not end on a digit")

	`FPDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(text_char) && $stable(last_char) && $stable(empty_text), "stalled output item changed")

endmodule

bind fixed_point_decimal_formatter_core fpdf_checker u_fpdf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.text_char  (text_char),
	.last_char  (last_char),
	.empty_text (empty_text)
);

`default_nettype wire
